>>> design/bresenham_line_rasterizer_unit_assert.svh
// Assertion helpers used by the rasterizer stepper module.
// Expects clk and rst_n in the enclosing scope.
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/brl_pkg.sv
package brl_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CANVAS_W      = 15;
    localparam int COLOR_W       = 32;
    localparam int CFG_INDEX_W   = 1;
    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 15'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CANVAS_WIDTH  = 1'b0,
        CFG_CANVAS_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } cmd_ctrl_t;

endpackage

>>> design/brl_front.sv
module brl_front #(
    parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_W     = 6 * COORD_WIDTH + 6 + brl_pkg::COLOR_W
) (
    input  logic                              mode,
    input  logic signed [COORD_WIDTH-1:0]     x_start,
    input  logic signed [COORD_WIDTH-1:0]     y_start,
    input  logic signed [COORD_WIDTH-1:0]     x_end,
    input  logic signed [COORD_WIDTH-1:0]     y_end,
    input  logic        [brl_pkg::COLOR_W-1:0] line_color,
    output logic        [ENTRY_W-1:0]         entry
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0]   x0_ext;
    logic signed [DW-1:0]   x1_ext;
    logic signed [DW-1:0]   y0_ext;
    logic signed [DW-1:0]   y1_ext;
    logic signed [DW-1:0]   dx_fwd;
    logic signed [DW-1:0]   dx_rev;
    logic signed [DW-1:0]   dy_fwd;
    logic signed [DW-1:0]   dy_rev;
    logic                   x_lt;
    logic                   y_lt;
    logic        [DW-1:0]   delta_x;
    logic signed [DW:0]     delta_y_neg;

    assign x0_ext = {x_start[COORD_WIDTH-1], x_start};
    assign x1_ext = {x_end[COORD_WIDTH-1], x_end};
    assign y0_ext = {y_start[COORD_WIDTH-1], y_start};
    assign y1_ext = {y_end[COORD_WIDTH-1], y_end};

    assign dx_fwd = x1_ext - x0_ext;
    assign dx_rev = x0_ext - x1_ext;
    assign dy_fwd = y1_ext - y0_ext;
    assign dy_rev = y0_ext - y1_ext;

    assign x_lt = x_start < x_end;
    assign y_lt = y_start < y_end;

    // Classify: absolute x span, negated absolute y span
    always_comb
    begin
        delta_x     = x_lt ? dx_fwd : dx_rev;
        delta_y_neg = y_lt ? {dy_rev[DW-1], dy_rev} : {dy_fwd[DW-1], dy_fwd};
    end

    assign entry = {mode, x_start, y_start, x_end, y_end, ~x_lt, ~y_lt,
                    delta_x, delta_y_neg, line_color};

endmodule

>>> design/brl_queue.sv
module brl_queue #(
    parameter int DEPTH   = brl_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   wr_data,
    output logic               full,
    output brl_pkg::cmd_ctrl_t ctrl_out,
    input  logic               rd_pop,
    output logic [WIDTH-1:0]   rd_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full           = (count_reg == CNT_W'(DEPTH));
    assign ctrl_out.valid = (count_reg != '0);
    assign ctrl_out.pop   = do_pop;
    assign rd_data        = slot_reg[rd_ptr_reg];
    assign do_push        = push && !full;
    assign do_pop         = rd_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/brl_stepper.sv
module brl_stepper #(
    parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_W     = 6 * COORD_WIDTH + 6 + brl_pkg::COLOR_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  brl_pkg::cmd_ctrl_t                  cmd_ctrl,
    input  logic [ENTRY_W-1:0]                  cmd_data,
    output logic                                cmd_pop,
    input  logic [brl_pkg::CANVAS_W-1:0]        canvas_width,
    input  logic [brl_pkg::CANVAS_W-1:0]        canvas_height,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [COORD_WIDTH-1:0]       pixel_x,
    output logic signed [COORD_WIDTH-1:0]       pixel_y,
    output logic [brl_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                visible,
    output logic                                last
);

    `include "bresenham_line_rasterizer_unit_assert.svh"

    localparam int CW    = COORD_WIDTH;
    localparam int EW    = CW + 3;
    localparam int E2W   = CW + 4;
    localparam int CMP_W = ((CW > brl_pkg::CANVAS_W) ? CW : brl_pkg::CANVAS_W) + 1;

    logic                        c_mode;
    logic signed [CW-1:0]        c_x0;
    logic signed [CW-1:0]        c_y0;
    logic signed [CW-1:0]        c_x1;
    logic signed [CW-1:0]        c_y1;
    logic                        c_dxn;
    logic                        c_dyn;
    logic        [CW:0]          c_delta_x;
    logic signed [CW+1:0]        c_delta_yn;
    logic [brl_pkg::COLOR_W-1:0] c_color;

    logic signed [CW-1:0]        cur_x_reg, cur_x_next;
    logic signed [CW-1:0]        cur_y_reg, cur_y_next;
    logic signed [CW-1:0]        end_x_reg, end_x_next;
    logic signed [CW-1:0]        end_y_reg, end_y_next;
    logic                        dxn_reg, dxn_next;
    logic                        dyn_reg, dyn_next;
    logic        [CW:0]          delta_x_reg, delta_x_next;
    logic signed [CW+1:0]        delta_yn_reg, delta_yn_next;
    logic signed [EW-1:0]        err_reg, err_next;
    logic [brl_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                        active_reg, active_next;

    logic                        out_valid_reg, out_valid_next;
    logic signed [CW-1:0]        out_x_reg, out_x_next;
    logic signed [CW-1:0]        out_y_reg, out_y_next;
    logic [brl_pkg::COLOR_W-1:0] out_color_reg, out_color_next;
    logic                        out_vis_reg, out_vis_next;
    logic                        out_last_reg, out_last_next;

    logic                        is_load;
    logic                        emit;
    logic                        out_taken;
    logic signed [E2W-1:0]       e2;
    logic signed [E2W-1:0]       dyn_wide;
    logic signed [E2W-1:0]       dx_wide;
    logic                        cond_x;
    logic                        cond_y;
    logic                        x_at_end;
    logic                        y_at_end;
    logic                        move_x;
    logic                        move_y;
    logic                        fin;
    logic signed [EW-1:0]        add_x;
    logic signed [EW-1:0]        add_y;
    logic signed [CMP_W-1:0]     x_cmp;
    logic signed [CMP_W-1:0]     y_cmp;
    logic signed [CMP_W-1:0]     w_cmp;
    logic signed [CMP_W-1:0]     h_cmp;
    logic                        vis;

    assign {c_mode, c_x0, c_y0, c_x1, c_y1, c_dxn, c_dyn,
            c_delta_x, c_delta_yn, c_color} = cmd_data;

    assign is_load   = (c_mode == brl_pkg::MODE_LOAD);
    assign out_taken = pop && out_valid_reg;
    assign cmd_pop   = cmd_ctrl.valid &&
                       (is_load || !active_reg || !out_valid_reg || pop);
    assign emit      = cmd_ctrl.pop && !is_load && active_reg;

    assign e2       = {err_reg, 1'b0};
    assign dyn_wide = E2W'(delta_yn_reg);
    assign dx_wide  = E2W'({1'b0, delta_x_reg});
    assign x_at_end = (cur_x_reg == end_x_reg);
    assign y_at_end = (cur_y_reg == end_y_reg);
    assign cond_x   = (e2 >= dyn_wide);
    assign move_x   = cond_x && !x_at_end;
    assign cond_y   = !(cond_x && x_at_end) && (e2 <= dx_wide);
    assign move_y   = cond_y && !y_at_end;
    assign fin      = (cond_x && x_at_end) || (cond_y && y_at_end);
    assign add_x    = move_x ? EW'(delta_yn_reg) : '0;
    assign add_y    = move_y ? EW'({1'b0, delta_x_reg}) : '0;

    assign x_cmp = CMP_W'(cur_x_reg);
    assign y_cmp = CMP_W'(cur_y_reg);
    assign w_cmp = CMP_W'({1'b0, canvas_width});
    assign h_cmp = CMP_W'({1'b0, canvas_height});
    assign vis   = !cur_x_reg[CW-1] && (x_cmp < w_cmp) &&
                   !cur_y_reg[CW-1] && (y_cmp < h_cmp);

    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        end_x_next    = end_x_reg;
        end_y_next    = end_y_reg;
        dxn_next      = dxn_reg;
        dyn_next      = dyn_reg;
        delta_x_next  = delta_x_reg;
        delta_yn_next = delta_yn_reg;
        err_next      = err_reg;
        color_next    = color_reg;
        active_next   = active_reg;
        if (cmd_ctrl.pop && is_load)
        begin
            cur_x_next    = c_x0;
            cur_y_next    = c_y0;
            end_x_next    = c_x1;
            end_y_next    = c_y1;
            dxn_next      = c_dxn;
            dyn_next      = c_dyn;
            delta_x_next  = c_delta_x;
            delta_yn_next = c_delta_yn;
            err_next      = EW'({1'b0, c_delta_x}) + EW'(c_delta_yn);
            color_next    = c_color;
            active_next   = 1'b1;
        end
        else if (emit)
        begin
            err_next = err_reg + add_x + add_y;
            if (move_x)
            begin
                cur_x_next = dxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (move_y)
            begin
                cur_y_next = dyn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            if (fin)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_vis_next   = out_vis_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_x_next     = cur_x_reg;
            out_y_next     = cur_y_reg;
            out_color_next = color_reg;
            out_vis_next   = vis;
            out_last_next  = fin;
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        end_x_reg     <= end_x_next;
        end_y_reg     <= end_y_next;
        dxn_reg       <= dxn_next;
        dyn_reg       <= dyn_next;
        delta_x_reg   <= delta_x_next;
        delta_yn_reg  <= delta_yn_next;
        err_reg       <= err_next;
        color_reg     <= color_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_vis_reg   <= out_vis_next;
        out_last_reg  <= out_last_next;
    end

    assign empty       = !out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign visible     = out_vis_reg;
    assign last        = out_last_reg;

    `BRL_ASSERT_NOW(a_emit_needs_slot, emit, !out_valid_reg || pop, "result overwritten")
    `BRL_ASSERT_NEXT(a_load_arms, cmd_ctrl.pop && is_load, active_reg, "load did not arm line")
    `BRL_ASSERT_NEXT(a_last_idles, emit && fin, !active_reg && out_last_reg, "end pixel kept line")
    `BRL_ASSERT_NEXT(a_hold_result, out_valid_reg && !pop,
        out_valid_reg && $stable(out_x_reg) && $stable(out_y_reg), "waiting result changed")

endmodule

>>> design/bresenham_line_rasterizer_unit.sv
// Channel   Handshake            Payload
// input     push / full          mode, x_start, y_start, x_end, y_end, line_color
// result    empty / pop          pixel_x, pixel_y, pixel_color, visible, last
// config    cfg_write            cfg_index, cfg_data (canvas_width, canvas_height)
//
// One item per cycle sustained while pop stays high; a step item passes through the queue
// and then the result register before its pixel shows on the result ports.
// Load and idle step items give no result and retire one per cycle.
// The command queue holds QUEUE_DEPTH items; full rises when all of them are occupied.
// A waiting result holds a step item at the queue head while a line is active.
// rst_n clears the queue, the result register's valid bit and the line's active bit.
module bresenham_line_rasterizer_unit #(
    parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = brl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  mode,
    input  logic signed [COORD_WIDTH-1:0]         x_start,
    input  logic signed [COORD_WIDTH-1:0]         y_start,
    input  logic signed [COORD_WIDTH-1:0]         x_end,
    input  logic signed [COORD_WIDTH-1:0]         y_end,
    input  logic        [brl_pkg::COLOR_W-1:0]    line_color,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [COORD_WIDTH-1:0]         pixel_x,
    output logic signed [COORD_WIDTH-1:0]         pixel_y,
    output logic        [brl_pkg::COLOR_W-1:0]    pixel_color,
    output logic                                  visible,
    output logic                                  last,
    input  logic                                  cfg_write,
    input  logic        [brl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [brl_pkg::CANVAS_W-1:0]   cfg_data
);

    localparam int ENTRY_W = 6 * COORD_WIDTH + 6 + brl_pkg::COLOR_W;

    logic [ENTRY_W-1:0]            entry;
    logic [ENTRY_W-1:0]            cmd_data;
    logic                          cmd_pop;
    brl_pkg::cmd_ctrl_t            cmd_ctrl;
    logic [brl_pkg::CANVAS_W-1:0]  canvas_width_reg;
    logic [brl_pkg::CANVAS_W-1:0]  canvas_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= brl_pkg::CANVAS_RESET;
            canvas_height_reg <= brl_pkg::CANVAS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                brl_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                brl_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    brl_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .mode       (mode),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .line_color (line_color),
        .entry      (entry)
    );

    brl_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (entry),
        .full     (full),
        .ctrl_out (cmd_ctrl),
        .rd_pop   (cmd_pop),
        .rd_data  (cmd_data)
    );

    brl_stepper #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_stepper (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_ctrl      (cmd_ctrl),
        .cmd_data      (cmd_data),
        .cmd_pop       (cmd_pop),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .empty         (empty),
        .pop           (pop),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .visible       (visible),
        .last          (last)
    );

endmodule

>>> dv/tb_bresenham_line_rasterizer_unit.sv
typedef struct {
    logic signed [brl_pkg::COORD_WIDTH_DEF-1:0] px;
    logic signed [brl_pkg::COORD_WIDTH_DEF-1:0] py;
    logic        [brl_pkg::COLOR_W-1:0]         color;
    logic                                       vis;
    logic                                       fin;
} pixel_t;

class pixel_scoreboard;
    int          pos_x, pos_y, goal_x, goal_y;
    bit          x_back, y_back;
    int          run_x, rise_neg, err_acc;
    logic [31:0] line_rgba;
    bit          drawing;
    int          canvas_w, canvas_h;
    pixel_t      pending_pixels[$];
    int          errors;

    function new();
        pos_x = 0; pos_y = 0; goal_x = 0; goal_y = 0;
        x_back = 0; y_back = 0;
        run_x = 0; rise_neg = 0; err_acc = 0;
        line_rgba = '0;
        drawing = 0;
        canvas_w = 1024;
        canvas_h = 1024;
        errors = 0;
    endfunction

    function void set_canvas(int w, int h);
        canvas_w = w;
        canvas_h = h;
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    function void note_item(brl_pkg::mode_t m, int xs, int ys, int xe, int ye,
                            logic [31:0] c);
        pixel_t p;
        int     e2;
        bit     done;
        if (m == brl_pkg::MODE_LOAD) begin
            pos_x = xs; pos_y = ys; goal_x = xe; goal_y = ye;
            x_back = !(xs < xe);
            y_back = !(ys < ye);
            run_x = (xe > xs) ? xe - xs : xs - xe;
            rise_neg = (ye > ys) ? ys - ye : ye - ys;
            err_acc = run_x + rise_neg;
            line_rgba = c;
            drawing = 1;
            return;
        end
        if (!drawing)
            return;
        p.px = pos_x[brl_pkg::COORD_WIDTH_DEF-1:0];
        p.py = pos_y[brl_pkg::COORD_WIDTH_DEF-1:0];
        p.color = line_rgba;
        p.vis = pos_x >= 0 && pos_x < canvas_w && pos_y >= 0 && pos_y < canvas_h;
        done = 0;
        e2 = 2 * err_acc;
        if (e2 >= rise_neg) begin
            if (pos_x == goal_x)
                done = 1;
            else begin
                err_acc += rise_neg;
                pos_x += x_back ? -1 : 1;
            end
        end
        if (!done && e2 <= run_x) begin
            if (pos_y == goal_y)
                done = 1;
            else begin
                err_acc += run_x;
                pos_y += y_back ? -1 : 1;
            end
        end
        if (done)
            drawing = 0;
        p.fin = done;
        pending_pixels = {pending_pixels, p};
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_pixel(logic signed [brl_pkg::COORD_WIDTH_DEF-1:0] x,
                              logic signed [brl_pkg::COORD_WIDTH_DEF-1:0] y,
                              logic [31:0] c, logic v, logic l);
        pixel_t p;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                     $time, x, y);
            errors++;
            return;
        end
        p = pending_pixels.pop_front();
        check_field("pixel_x", p.px, x);
        check_field("pixel_y", p.py, y);
        check_field("pixel_color", longint'(p.color), longint'(c));
        check_field("visible", p.vis, v);
        check_field("last", p.fin, l);
    endfunction
endclass

module tb_bresenham_line_rasterizer_unit;
    localparam int CW = brl_pkg::COORD_WIDTH_DEF;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             push = 1'b0;
    logic                             full;
    logic                             mode = 1'b0;
    logic signed [CW-1:0]             x_start = '0;
    logic signed [CW-1:0]             y_start = '0;
    logic signed [CW-1:0]             x_end = '0;
    logic signed [CW-1:0]             y_end = '0;
    logic [brl_pkg::COLOR_W-1:0]      line_color = '0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic signed [CW-1:0]             pixel_x;
    logic signed [CW-1:0]             pixel_y;
    logic [brl_pkg::COLOR_W-1:0]      pixel_color;
    logic                             visible;
    logic                             last;
    logic                             cfg_write = 1'b0;
    logic [brl_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [brl_pkg::CANVAS_W-1:0]     cfg_data = '0;

    pixel_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;
    int canvas_w = 1024;
    int canvas_h = 1024;

    bresenham_line_rasterizer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .mode(mode), .x_start(x_start), .y_start(y_start),
        .x_end(x_end), .y_end(y_end), .line_color(line_color),
        .empty(empty), .pop(pop),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
        .visible(visible), .last(last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 500000);
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_item(brl_pkg::mode_t'(mode), x_start, y_start, x_end, y_end,
                             line_color);
            if (pop && !empty)
                sb.check_pixel(pixel_x, pixel_y, pixel_color, visible, last);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(brl_pkg::mode_t m, int xs, int ys, int xe, int ye,
                             logic [31:0] c);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        push <= 1'b1;
        mode <= m;
        x_start <= xs[CW-1:0];
        y_start <= ys[CW-1:0];
        x_end <= xe[CW-1:0];
        y_end <= ye[CW-1:0];
        line_color <= c;
        do @(posedge clk); while (full);
    endtask

    task automatic send_steps(int n);
        repeat (n)
            send_item(brl_pkg::MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain_pixels();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_canvas(int w, int h);
        cfg_write <= 1'b1;
        cfg_index <= brl_pkg::CFG_CANVAS_WIDTH;
        cfg_data <= w[brl_pkg::CANVAS_W-1:0];
        @(posedge clk);
        cfg_index <= brl_pkg::CFG_CANVAS_HEIGHT;
        cfg_data <= h[brl_pkg::CANVAS_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        canvas_w = w;
        canvas_h = h;
        sb.set_canvas(w, h);
    endtask

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int near_coord(int limit);
        case ($urandom_range(3))
            0: return int'($urandom_range(12)) - 6;
            1: return clamp_coord(limit + int'($urandom_range(12)) - 6);
            2: return int'($urandom_range(limit));
            default: return $urandom_range(1) ? 32767 - int'($urandom_range(10))
                                               : -32768 + int'($urandom_range(10));
        endcase
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic draw_random(int target);
        int sent, kind, n, span, xs, ys, xe, ye, ax, ay;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                n = $urandom_range(1, 3);
                send_steps(n);
                sent += n;
            end
            else if (kind < 20)
            begin
                send_item(brl_pkg::MODE_LOAD, full_coord(), full_coord(), full_coord(),
                          full_coord(), $urandom);
                n = $urandom_range(1, 6);
                send_steps(n);
                sent += n + 1;
            end
            else
            begin
                span = ($urandom_range(9) == 0) ? 60 : 12;
                xs = near_coord(canvas_w);
                ys = near_coord(canvas_h);
                xe = clamp_coord(xs + int'($urandom_range(2 * span)) - span);
                ye = clamp_coord(ys + int'($urandom_range(2 * span)) - span);
                ax = (xe > xs) ? xe - xs : xs - xe;
                ay = (ye > ys) ? ye - ys : ys - ye;
                n = ((ax > ay) ? ax : ay) + 1;
                if (kind < 30)
                    n = $urandom_range(1, n);
                send_item(brl_pkg::MODE_LOAD, xs, ys, xe, ye, $urandom);
                send_steps(n);
                sent += n + 1;
                if ($urandom_range(3) == 0)
                    send_steps(1);
            end
        end
    endtask

    initial
    begin
        int w, h;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_steps(1);
        send_item(brl_pkg::MODE_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_steps(1);
        send_item(brl_pkg::MODE_LOAD, -32768, -32768, 32767, 32767, 32'h0000_0000);
        send_steps(3);
        send_item(brl_pkg::MODE_LOAD, 32767, 32767, -32768, -32768, 32'hA5A5_A5A5);
        send_steps(2);
        send_item(brl_pkg::MODE_LOAD, 5, 3, 2, 7, 32'h1234_5678);
        send_steps(6);
        send_item(brl_pkg::MODE_LOAD, 1023, 0, 1025, 2, 32'h5A5A_5A5A);
        send_steps(3);
        send_item(brl_pkg::MODE_LOAD, -1, 1, 1, -1, 32'h8000_0001);
        send_steps(3);
        drain_pixels();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin w = 32767; h = 32767; end
                1: begin w = 0; h = 0; end
                2: begin w = 40; h = 24; end
                3: begin w = 1; h = 1; end
                4: begin w = 1024; h = 768; end
                5: begin w = 20; h = 32767; end
                6: begin w = 0; h = 50; end
                default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
            endcase
            write_canvas(w, h);
            case (p % 4)
                0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
                1: begin tx_idle_pct = 70; rx_stall_pct = 0; end
                2: begin tx_idle_pct = 0; rx_stall_pct = 70; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            if (p == 4)
                hold_request = 300;
            draw_random(210);
            drain_pixels();
        end

        if (sb.pending() != 0)
            $display("%0t: %0d pixels never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/brl_pkg.sv
design/brl_front.sv
design/brl_queue.sv
design/brl_stepper.sv
design/bresenham_line_rasterizer_unit.sv
dv/tb_bresenham_line_rasterizer_unit.sv
